>>> sv/perlin_noise_3d_top_defines.svh
// Assertion macros for the 3D gradient noise block
`ifndef PERLIN_NOISE_3D_TOP_DEFINES_SVH
`define PERLIN_NOISE_3D_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define PN3_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pn3 implication check failed");

// next-cycle implication, disabled while reset is high
`define PN3_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pn3 next-cycle check failed");

`endif

>>> sv/pn3_pkg.sv
// Shared types and constants for the 3D gradient noise block
`timescale 1ns / 1ps
package pn3_pkg;
   localparam int unsigned TW = 16;   // Q16 fraction
   localparam int unsigned FW = 17;   // fade, Q16 in [0, 65536]
   localparam int unsigned VW = 19;   // gradient and lerp values
   localparam int unsigned PW = 38;   // lerp products
   localparam int unsigned NW = 16;   // noise output

   localparam logic KIND_EVAL  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef logic [3:0] hash_type;

   typedef struct packed {
      logic       wr;
      logic [7:0] entry_index;
      logic [7:0] entry_value;
   } ctl_type;
endpackage

>>> sv/perlin_noise_3d_top.sv
// Results: an accepted evaluate transaction gives one result; write transactions give none.
// Throughput: one transaction per cycle while req_stall is low; the lookup pipeline reads replicated
// table copies at each hash level, so no table port is shared between items.
// Reset: synchronous; the table is refilled with the identity permutation by a pass over all
// TABLE_ENTRIES entries after reset, during which req_stall is high.
`timescale 1ns / 1ps
`include "perlin_noise_3d_top_defines.svh"
module perlin_noise_3d_top import pn3_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = 256,
   parameter int unsigned FRAC_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [23:0] req_coord_x,
   input  logic signed [23:0] req_coord_y,
   input  logic signed [23:0] req_coord_z,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_entry_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_noise_value
);
   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [9:0]    vld_ff;
   logic          adv, acc;
   ctl_type       ctl;
   logic [AW-1:0] cx, cy, cz;
   logic [TW-1:0] tx, ty, tz;
   logic [TW-1:0] fx_ff [3];
   logic [TW-1:0] fy_ff [3];
   logic [TW-1:0] fz_ff [3];
   logic [FW-1:0] fu, fv, fw;
   hash_type [7:0] hashes;
   logic signed [47:0] ex, ey, ez;

   always_comb begin
      adv       = !(vld_ff[9] && rsp_stall);
      req_stall = clr_busy_ff || !adv;
      acc       = req_valid && !req_stall;
      rsp_valid = vld_ff[9];

      ctl.wr          = acc && (req_kind == KIND_WRITE)
                        && (32'(req_entry_index) < TABLE_ENTRIES);
      ctl.entry_index = req_entry_index;
      ctl.entry_value = req_entry_value;

      ex = 48'(req_coord_x);
      ey = 48'(req_coord_y);
      ez = 48'(req_coord_z);
      cx = ex[FRAC_BITS +: AW];
      cy = ey[FRAC_BITS +: AW];
      cz = ez[FRAC_BITS +: AW];
      tx = TW'({req_coord_x[FRAC_BITS-1:0], 16'b0} >> FRAC_BITS);
      ty = TW'({req_coord_y[FRAC_BITS-1:0], 16'b0} >> FRAC_BITS);
      tz = TW'({req_coord_z[FRAC_BITS-1:0], 16'b0} >> FRAC_BITS);

      clr_cnt_in  = clr_busy_ff ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      clr_busy_in = clr_busy_ff && (clr_cnt_ff != LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         vld_ff      <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
         if (adv) begin
            vld_ff <= {vld_ff[8:0], acc && (req_kind == KIND_EVAL)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fx_ff[0] <= tx;
         fy_ff[0] <= ty;
         fz_ff[0] <= tz;
         for (int i = 1; i < 3; i++) begin
            fx_ff[i] <= fx_ff[i-1];
            fy_ff[i] <= fy_ff[i-1];
            fz_ff[i] <= fz_ff[i-1];
         end
      end
   end

   pn3_fade u_fade_x (.clock(clock), .adv(adv), .t(tx), .fade_ff(fu));
   pn3_fade u_fade_y (.clock(clock), .adv(adv), .t(ty), .fade_ff(fv));
   pn3_fade u_fade_z (.clock(clock), .adv(adv), .t(tz), .fade_ff(fw));

   pn3_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
      .clock(clock), .reset(reset), .adv(adv),
      .clr_en(clr_busy_ff), .clr_addr(clr_cnt_ff),
      .ctl(ctl), .cx(cx), .cy(cy), .cz(cz),
      .hashes(hashes)
   );

   pn3_interp u_interp (
      .clock(clock), .adv(adv), .hashes(hashes),
      .fx(fx_ff[2]), .fy(fy_ff[2]), .fz(fz_ff[2]),
      .fu(fu), .fv(fv), .fw(fw),
      .noise_ff(rsp_noise_value)
   );

   `PN3_ASSERT_NXT(a_clr_done, clr_busy_ff && (clr_cnt_ff == LAST), !clr_busy_ff)
   `PN3_ASSERT_NXT(a_hold_on_stall, !adv, $stable(vld_ff))
   `PN3_ASSERT_IMP(a_rsp_from_pipe, $rose(rsp_valid), $past(vld_ff[8]))
endmodule

>>> sv/pn3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read
`timescale 1ns / 1ps
module pn3_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end
endmodule

>>> sv/pn3_fade.sv
// Three-stage quintic fade 6t^5-15t^4+10t^3 in Q16
`timescale 1ns / 1ps
module pn3_fade import pn3_pkg::*; (
   input  logic          clock,
   input  logic          adv,
   input  logic [TW-1:0] t,
   output logic [FW-1:0] fade_ff
);
   logic [31:0] t2_ff;
   logic [TW-1:0] tq_ff;
   logic [31:0] t3_ff;
   logic [19:0] q16_ff;
   logic [31:0] t3_in;
   logic [36:0] q_in;
   logic [FW-1:0] fade_in;

   always_comb begin
      t3_in   = 32'((48'(t2_ff) * 48'(tq_ff)) >> 16);
      q_in    = 37'(t2_ff) * 37'd6 + (37'd10 << 32) - ((37'(tq_ff) * 37'd15) << 16);
      fade_in = FW'((52'(t3_ff) * 52'(q16_ff)) >> 32);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_ff   <= 32'(t) * 32'(t);
         tq_ff   <= t;
         t3_ff   <= t3_in;
         q16_ff  <= q_in[35:16];
         fade_ff <= fade_in;
      end
   end
endmodule

>>> sv/pn3_hash.sv
// Permutation table lookups: three levels of table copies giving eight corner hashes
`timescale 1ns / 1ps
module pn3_hash import pn3_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = 256,
   localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                clr_en,
   input  logic [AW-1:0]       clr_addr,
   input  ctl_type             ctl,
   input  logic [AW-1:0]       cx,
   input  logic [AW-1:0]       cy,
   input  logic [AW-1:0]       cz,
   output hash_type [7:0]      hashes
);
   localparam int unsigned SW = (AW > 8) ? AW : 8;
   localparam logic [AW-1:0] ONE = AW'(1);

   logic          wr1_ff, wr2_ff;
   logic [7:0]    idx1_ff, idx2_ff, val1_ff, val2_ff;
   logic [AW-1:0] y1_ff, z1_ff, z2_ff;

   logic [7:0]    rd1 [2];
   logic [7:0]    rd2 [4];
   logic [7:0]    rd3 [8];
   logic [AW-1:0] ra1 [2];
   logic [AW-1:0] ra2 [4];
   logic [AW-1:0] ra3 [8];
   logic [AW-1:0] a_hash, b_hash, aa, ab, ba, bb;

   logic          we1, we2, we3;
   logic [AW-1:0] wa1, wa2, wa3;
   logic [7:0]    wd1, wd2, wd3;

   function automatic logic [AW-1:0] addm(logic [7:0] p, logic [AW-1:0] c);
      logic [SW-1:0] s;
      s = SW'(p) + SW'(c);
      return s[AW-1:0];
   endfunction

   always_comb begin
      we1 = clr_en | (adv & ctl.wr);
      wa1 = clr_en ? clr_addr : AW'(ctl.entry_index);
      wd1 = clr_en ? 8'(clr_addr) : ctl.entry_value;
      we2 = clr_en | (adv & wr1_ff);
      wa2 = clr_en ? clr_addr : AW'(idx1_ff);
      wd2 = clr_en ? 8'(clr_addr) : val1_ff;
      we3 = clr_en | (adv & wr2_ff);
      wa3 = clr_en ? clr_addr : AW'(idx2_ff);
      wd3 = clr_en ? 8'(clr_addr) : val2_ff;

      ra1[0] = cx;
      ra1[1] = cx + ONE;

      a_hash = addm(rd1[0], y1_ff);
      b_hash = addm(rd1[1], y1_ff);
      ra2[0] = a_hash;
      ra2[1] = a_hash + ONE;
      ra2[2] = b_hash;
      ra2[3] = b_hash + ONE;

      aa = addm(rd2[0], z2_ff);
      ab = addm(rd2[1], z2_ff);
      ba = addm(rd2[2], z2_ff);
      bb = addm(rd2[3], z2_ff);
      ra3[0] = aa;
      ra3[1] = ba;
      ra3[2] = ab;
      ra3[3] = bb;
      ra3[4] = aa + ONE;
      ra3[5] = ba + ONE;
      ra3[6] = ab + ONE;
      ra3[7] = bb + ONE;

      for (int i = 0; i < 8; i++) begin
         hashes[i] = rd3[i][3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr1_ff <= 1'b0;
         wr2_ff <= 1'b0;
      end else if (adv) begin
         wr1_ff <= ctl.wr;
         wr2_ff <= wr1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx1_ff <= ctl.entry_index;
         val1_ff <= ctl.entry_value;
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;
         y1_ff   <= cy;
         z1_ff   <= cz;
         z2_ff   <= z1_ff;
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_lvl1
      pn3_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
         .clock(clock), .we(we1), .waddr(wa1), .wdata(wd1),
         .re(adv), .raddr(ra1[g]), .rdata_ff(rd1[g])
      );
   end

   for (genvar g = 0; g < 4; g++) begin : g_lvl2
      pn3_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
         .clock(clock), .we(we2), .waddr(wa2), .wdata(wd2),
         .re(adv), .raddr(ra2[g]), .rdata_ff(rd2[g])
      );
   end

   for (genvar g = 0; g < 8; g++) begin : g_lvl3
      pn3_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
         .clock(clock), .we(we3), .waddr(wa3), .wdata(wd3),
         .re(adv), .raddr(ra3[g]), .rdata_ff(rd3[g])
      );
   end
endmodule

>>> sv/pn3_interp.sv
// Gradients and trilinear interpolation pipeline with output rounding and saturation
`timescale 1ns / 1ps
module pn3_interp import pn3_pkg::*; (
   input  logic                  clock,
   input  logic                  adv,
   input  hash_type [7:0]        hashes,
   input  logic [TW-1:0]         fx,
   input  logic [TW-1:0]         fy,
   input  logic [TW-1:0]         fz,
   input  logic [FW-1:0]         fu,
   input  logic [FW-1:0]         fv,
   input  logic [FW-1:0]         fw,
   output logic signed [NW-1:0]  noise_ff
);
   localparam logic signed [VW-1:0] ONE_Q16 = VW'(65536);
   localparam logic signed [PW-1:0] HALF_Q16 = PW'(32768);

   logic signed [VW-1:0] g_ff [8];
   logic [FW-1:0]        u4_ff, v4_ff, w4_ff, v5_ff, w5_ff, v6_ff, w6_ff, w7_ff, w8_ff;
   logic signed [PW-1:0] mx_ff [4];
   logic signed [VW-1:0] a5_ff [4];
   logic signed [VW-1:0] lx_ff [4];
   logic signed [PW-1:0] my_ff [2];
   logic signed [VW-1:0] a7_ff [2];
   logic signed [VW-1:0] ly_ff [2];
   logic signed [PW-1:0] mz_ff;
   logic signed [VW-1:0] a9_ff;

   logic signed [VW-1:0] px0, px1, py0, py1, pz0, pz1;
   logic signed [VW-1:0] g_in [8];
   logic signed [VW-1:0] r_in;
   logic signed [VW-1:0] rr_in;
   logic signed [NW-1:0] noise_in;

   function automatic logic signed [VW-1:0] grad(hash_type h, logic signed [VW-1:0] x,
                                                 logic signed [VW-1:0] y,
                                                 logic signed [VW-1:0] z);
      logic signed [VW-1:0] u;
      logic signed [VW-1:0] v;
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : ((h inside {4'd12, 4'd14}) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic signed [PW-1:0] lmul(logic signed [VW-1:0] a,
                                                 logic signed [VW-1:0] b,
                                                 logic [FW-1:0] w);
      logic signed [VW:0]   d;
      logic signed [FW:0]   ws;
      d  = (VW+1)'(b) - (VW+1)'(a);
      ws = signed'({1'b0, w});
      return PW'(d) * PW'(ws);
   endfunction

   function automatic logic signed [VW-1:0] rnd(logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = (p + HALF_Q16) >>> 16;
      return s[VW-1:0];
   endfunction

   always_comb begin
      px0 = signed'(VW'(fx));
      py0 = signed'(VW'(fy));
      pz0 = signed'(VW'(fz));
      px1 = px0 - ONE_Q16;
      py1 = py0 - ONE_Q16;
      pz1 = pz0 - ONE_Q16;
      for (int i = 0; i < 8; i++) begin
         g_in[i] = grad(hashes[i], i[0] ? px1 : px0, i[1] ? py1 : py0, i[2] ? pz1 : pz0);
      end
      r_in  = a9_ff + rnd(mz_ff);
      rr_in = (r_in + VW'(2)) >>> 2;
      if (rr_in > VW'(32767)) begin
         noise_in = 16'sd32767;
      end else if (rr_in < -VW'(32768)) begin
         noise_in = -16'sd32768;
      end else begin
         noise_in = rr_in[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 8; i++) begin
            g_ff[i] <= g_in[i];
         end
         u4_ff <= fu;
         v4_ff <= fv;
         w4_ff <= fw;
         for (int k = 0; k < 4; k++) begin
            mx_ff[k] <= lmul(g_ff[2*k], g_ff[2*k+1], u4_ff);
            a5_ff[k] <= g_ff[2*k];
            lx_ff[k] <= a5_ff[k] + rnd(mx_ff[k]);
         end
         v5_ff <= v4_ff;
         w5_ff <= w4_ff;
         v6_ff <= v5_ff;
         w6_ff <= w5_ff;
         for (int j = 0; j < 2; j++) begin
            my_ff[j] <= lmul(lx_ff[2*j], lx_ff[2*j+1], v6_ff);
            a7_ff[j] <= lx_ff[2*j];
            ly_ff[j] <= a7_ff[j] + rnd(my_ff[j]);
         end
         w7_ff    <= w6_ff;
         w8_ff    <= w7_ff;
         mz_ff    <= lmul(ly_ff[0], ly_ff[1], w8_ff);
         a9_ff    <= ly_ff[0];
         noise_ff <= noise_in;
      end
   end
endmodule

>>> bench/perlin_noise_3d_checker.sv
// Checker for the 3D gradient noise block: predicts each noise value and compares results
`timescale 1ns / 1ps
module perlin_noise_3d_checker import pn3_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_kind,
   input  logic signed [23:0] req_coord_x,
   input  logic signed [23:0] req_coord_y,
   input  logic signed [23:0] req_coord_z,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_entry_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_noise_value,
   output int                 fail_count,
   output int                 pending
);
   logic [7:0] perm [256];
   logic signed [15:0] noise_queue [$];

   function automatic longint smooth_step(longint t);
      longint unsigned tt, t2, t3, q;
      tt = t;
      t2 = tt * tt;
      t3 = (t2 * tt) >> 16;
      q = 6 * t2 + 10 * (64'd1 << 32) - 15 * tt * 65536;
      return longint'((t3 * (q >> 16)) >> 32);
   endfunction

   function automatic longint blend(longint w, longint a, longint b);
      return a + ((((b - a) * w) + 32768) >>> 16);
   endfunction

   function automatic longint grad(logic [7:0] hash, longint x, longint y, longint z);
      logic [3:0] h;
      longint u, v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic signed [15:0] noise_at(logic signed [23:0] cx,
                                                   logic signed [23:0] cy,
                                                   logic signed [23:0] cz);
      logic [7:0] xi, yi, zi, a, aa, ab, b, ba, bb;
      longint x, y, z, x1, y1, z1, u, v, w, r;
      xi = cx[19:12];
      yi = cy[19:12];
      zi = cz[19:12];
      x = longint'(cx[11:0]) << 4;
      y = longint'(cy[11:0]) << 4;
      z = longint'(cz[11:0]) << 4;
      x1 = x - 65536;
      y1 = y - 65536;
      z1 = z - 65536;
      u = smooth_step(x);
      v = smooth_step(y);
      w = smooth_step(z);
      a = perm[xi] + yi;
      aa = perm[a] + zi;
      ab = perm[8'(a + 1)] + zi;
      b = perm[8'(xi + 1)] + yi;
      ba = perm[b] + zi;
      bb = perm[8'(b + 1)] + zi;
      r = blend(w,
         blend(v,
            blend(u, grad(perm[aa], x, y, z), grad(perm[ba], x1, y, z)),
            blend(u, grad(perm[ab], x, y1, z), grad(perm[bb], x1, y1, z))),
         blend(v,
            blend(u, grad(perm[8'(aa + 1)], x, y, z1), grad(perm[8'(ba + 1)], x1, y, z1)),
            blend(u, grad(perm[8'(ab + 1)], x, y1, z1),
                  grad(perm[8'(bb + 1)], x1, y1, z1))));
      r = (r + 2) >>> 2;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   initial begin
      fail_count = 0;
      for (int i = 0; i < 256; i++) perm[i] = 8'(i);
   end

   assign pending = noise_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 256; i++) perm[i] <= 8'(i);
         noise_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (noise_queue.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %0d",
                        $time, rsp_noise_value);
               fail_count++;
            end else begin
               if (rsp_noise_value !== noise_queue[0]) begin
                  $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                           $time, noise_queue[0], rsp_noise_value);
                  fail_count++;
               end
               void'(noise_queue.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_EVAL)
               noise_queue.push_back(noise_at(req_coord_x, req_coord_y, req_coord_z));
            else
               perm[req_entry_index] <= req_entry_value;
         end
      end
   end
endmodule

>>> bench/perlin_noise_3d_top_tb.sv
// Testbench top for the 3D gradient noise block: stimulus, idling and stalling phases and verdict
`timescale 1ns / 1ps
module perlin_noise_3d_top_tb import pn3_pkg::*;;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_kind;
   logic signed [23:0] req_coord_x;
   logic signed [23:0] req_coord_y;
   logic signed [23:0] req_coord_z;
   logic [7:0]         req_entry_index;
   logic [7:0]         req_entry_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_noise_value;
   int                 fail_count;
   int                 pending;
   int                 idle_pct;
   int                 stall_pct;
   int                 cycles;

   perlin_noise_3d_top uut (.*);

   perlin_noise_3d_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("perlin_noise_3d_top verification failed");
         $finish;
      end
   end

   initial rsp_stall = 1'b0;
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic send(logic kind, logic signed [23:0] x, logic signed [23:0] y,
                       logic signed [23:0] z, logic [7:0] idx, logic [7:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_entry_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic signed [23:0] pick_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(65535)) - 32768);
         2: return 24'(($signed($urandom_range(511)) - 256) * 4096
                       + $signed($urandom_range(2)) - 1);
         default: return 24'($signed($urandom_range(4095)) - 2048);
      endcase
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 15)
            send(KIND_WRITE, 24'($urandom), 24'($urandom), 24'($urandom),
                 8'($urandom), 8'($urandom));
         else
            send(KIND_EVAL, pick_coord(), pick_coord(), pick_coord(),
                 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_EVAL;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      req_entry_index = '0;
      req_entry_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(KIND_EVAL, 24'sd0, 24'sd0, 24'sd0, 8'd0, 8'd0);
      send(KIND_EVAL, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 8'hFF, 8'hFF);
      send(KIND_EVAL, 24'sh800000, 24'sh800000, 24'sh800000, 8'd0, 8'd0);
      send(KIND_EVAL, -24'sd1, -24'sd1, -24'sd1, 8'h55, 8'hAA);
      send(KIND_EVAL, 24'sh000800, 24'sh000800, 24'sh000800, 8'd0, 8'd0);
      send(KIND_EVAL, 24'sh7FFFFF, 24'sh800000, -24'sd4096, 8'd0, 8'd0);
      send(KIND_EVAL, -24'sd2048, 24'sh000FFF, 24'sh001000, 8'd0, 8'd0);
      send(KIND_EVAL, 24'sh0FF800, 24'sh100800, -24'sh000800, 8'd0, 8'd0);
      send(KIND_WRITE, 24'sh7FFFFF, 24'sh800000, -24'sd1, 8'd0, 8'hFF);
      send(KIND_WRITE, 24'sd0, 24'sd0, 24'sd0, 8'hFF, 8'd0);
      send(KIND_WRITE, 24'sd0, 24'sd0, 24'sd0, 8'd1, 8'h80);
      send(KIND_EVAL, 24'sd0, 24'sd0, 24'sd0, 8'd0, 8'd0);
      send(KIND_EVAL, -24'sd1, -24'sd1, -24'sd1, 8'd0, 8'd0);
      send(KIND_EVAL, 24'sh0FF800, 24'sh0FF400, 24'sh0FFC00, 8'd0, 8'd0);
      for (int h = 0; h < 16; h += 5)
         send(KIND_WRITE, 24'sd0, 24'sd0, 24'sd0, 8'(h + 2), 8'(h * 17));
      send(KIND_EVAL, 24'sh001400, 24'sh002C00, 24'sh003800, 8'd0, 8'd0);

      random_items(100);
      idle_pct = 48;
      random_items(95);
      idle_pct = 0;
      stall_pct = 48;
      random_items(95);
      idle_pct = 24;
      stall_pct = 24;
      random_items(95);
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("perlin_noise_3d_top verification clean");
      else
         $display("perlin_noise_3d_top verification failed");
      $finish;
   end
endmodule
